### rtl/assert_macros.svh
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked every clock, quiet in reset.
`define AST_IMP(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
// Next-cycle implication.
`define AST_NXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`endif

### rtl/grc_pkg.sv
// Package: constants and beat types of the grid ray caster.
`default_nettype none
package grc_pkg;
  localparam int MAP_SIZE_DEF  = 16;
  localparam int FRAC_BITS_DEF = 12;
  localparam int DIR_FRAC      = 14;

  localparam logic OP_ROW  = 1'b0;
  localparam logic OP_CAST = 1'b1;

  typedef struct packed {
    logic        op;
    logic [3:0]  row_index;
    logic [15:0] row_bits;
    logic [15:0] start_x;
    logic [15:0] start_y;
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
  } grc_in_t;

  typedef struct packed {
    logic        hit;
    logic        side;
    logic [3:0]  tile_x;
    logic [3:0]  tile_y;
    logic [17:0] ray_length;
    logic [16:0] end_x;
    logic [16:0] end_y;
  } grc_out_t;

  // cast job handed from front to back
  typedef struct packed {
    logic        oob;
    logic        nx;
    logic        ny;
    logic [15:0] ax;
    logic [15:0] ay;
    logic [15:0] sx;
    logic [15:0] sy;
  } grc_job_t;
endpackage
`default_nettype wire

### rtl/grid_ray_cast_dda.sv
// Top level of the grid ray caster.
// Usage:
//  - Input beats: drive in_data with start high; a beat is taken on a
//    clock edge where start is high and busy is low.
//  - op row write stores one map row (rows past the map are ignored) and
//    gives no result. op cast gives exactly one result beat.
//  - Results appear on out_data for one cycle with out_strobe high; the
//    receiver cannot stall, so nothing waits on it.
//  - A two-entry job queue sits between the front (accept and classify)
//    and the back (divide, walk, end point). busy is high while it is full,
//    and for a row write while any cast is queued or in flight, so a cast
//    always walks the map as it stood when the cast was taken.
//  - A cast passes in order through the queue, the pop, two bit-serial
//    reciprocal divides of DIR_FRAC+FRAC_BITS+1 quotient bits each, an
//    init step, the walk (one tile step per cycle, 1 to 2*MAP_SIZE steps,
//    none for a start off the map), the end point on a hit and the output
//    state and register.
//  - Reset clears the map to open and empties the queue.
`default_nettype none
`include "assert_macros.svh"
module grid_ray_cast_dda import grc_pkg::*; #(
  parameter int MAP_SIZE  = MAP_SIZE_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    start,
  output logic         busy,
  input  wire grc_in_t in_data,
  output logic         out_strobe,
  output grc_out_t     out_data
);
  logic take, row_we, q_full, q_valid, q_pop, idle;
  logic [3:0] row_idx;
  logic [15:0] row_val;
  grc_job_t q_job;

  // row writes wait for the back to drain
  assign busy = q_full || (in_data.op == OP_ROW && !idle);
  assign take = start && !busy;

  grc_front #(.MAP_SIZE(MAP_SIZE), .FRAC_BITS(FRAC_BITS)) u_front (
    .clk, .rst_n, .take, .in_data, .row_we, .row_idx, .row_val,
    .q_full, .q_valid, .q_job, .q_pop);

  grc_back #(.MAP_SIZE(MAP_SIZE), .FRAC_BITS(FRAC_BITS)) u_back (
    .clk, .rst_n, .q_valid, .q_job, .q_pop, .row_we, .row_idx, .row_val,
    .out_strobe, .out_data, .idle);

  // a pop only happens with something queued
  `AST_IMP(a_pop_valid, clk, rst_n, q_pop, q_valid)
  // a result is never shown back to back
  `AST_NXT(a_strobe_single, clk, rst_n, out_strobe, !out_strobe)
  // when idle, nothing comes out next
  `AST_NXT(a_idle_quiet, clk, rst_n, idle && !take, !out_strobe)
endmodule
`default_nettype wire

### rtl/grc_front.sv
// Front end: takes beats, writes map rows, queues cast jobs.
`default_nettype none
module grc_front import grc_pkg::*; #(
  parameter int MAP_SIZE  = MAP_SIZE_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     take,
  input  wire grc_in_t  in_data,
  output logic          row_we,
  output logic [3:0]    row_idx,
  output logic [15:0]   row_val,
  output logic          q_full,
  output logic          q_valid,
  output grc_job_t      q_job,
  input  wire logic     q_pop
);
  localparam int TB = 16 - FRAC_BITS;
  grc_job_t q_r [2];
  logic     wp_r, rp_r;
  logic [1:0] cnt_r;
  grc_job_t job;
  logic [TB-1:0] tx, ty;
  logic push;

  always_comb begin
    tx = in_data.start_x[15 -: TB];
    ty = in_data.start_y[15 -: TB];
    job.oob = (32'(tx) >= 32'(MAP_SIZE)) || (32'(ty) >= 32'(MAP_SIZE));
    job.nx = in_data.dir_x[15];
    job.ny = in_data.dir_y[15];
    job.ax = in_data.dir_x[15] ? 16'(-in_data.dir_x) : in_data.dir_x;
    job.ay = in_data.dir_y[15] ? 16'(-in_data.dir_y) : in_data.dir_y;
    job.sx = in_data.start_x;
    job.sy = in_data.start_y;
  end

  assign push    = take && in_data.op == OP_CAST;
  assign row_we  = take && in_data.op == OP_ROW && 32'(in_data.row_index) < 32'(MAP_SIZE);
  assign row_idx = in_data.row_index;
  assign row_val = in_data.row_bits;
  assign q_full  = cnt_r == 2'd2;
  assign q_valid = cnt_r != 2'd0;
  assign q_job   = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) q_r[wp_r] <= job;
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (q_pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(q_pop);
    end
  end
endmodule
`default_nettype wire

### rtl/grc_back.sv
// Back end: reciprocal divider, DDA walk, end point, result beat.
`default_nettype none
module grc_back import grc_pkg::*; #(
  parameter int MAP_SIZE  = MAP_SIZE_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     q_valid,
  input  wire grc_job_t q_job,
  output logic          q_pop,
  input  wire logic     row_we,
  input  wire logic [3:0]  row_idx,
  input  wire logic [15:0] row_val,
  output logic          out_strobe,
  output grc_out_t      out_data,
  output logic          idle
);
  localparam int NB  = DIR_FRAC + FRAC_BITS;   // numerator exponent
  localparam int DW  = NB + 1;                 // step length width
  // side distance width: start distance plus one step length per walk step
  localparam int SW  = DW + $clog2(2 * MAP_SIZE + 2);
  localparam int TW  = $clog2(MAP_SIZE) + 2;   // signed tile index
  localparam int KW  = $clog2(2 * MAP_SIZE + 1);
  localparam logic [DW-1:0] RSAT = {DW{1'b1}};
  localparam logic [SW-1:0] LMAX = SW'(18'h3FFFF);
  localparam logic [16:0]   TOP  = 17'(MAP_SIZE << FRAC_BITS);
  localparam logic [FRAC_BITS:0] ONE = (FRAC_BITS+1)'(1) << FRAC_BITS;

  localparam logic [2:0] S_IDLE = 3'd0, S_DIV = 3'd1, S_INIT = 3'd2,
                         S_WALK = 3'd3, S_END = 3'd4, S_OUT = 3'd5;

  logic [MAP_SIZE-1:0] rows_r [MAP_SIZE];
  logic [2:0]  st_r;
  grc_job_t    j_r;
  logic [5:0]  bit_r;
  logic        axis_r;
  logic [NB:0] rem_r;
  logic [DW-1:0] dx_r, dy_r, quo_r;
  logic [SW-1:0] sdx_r, sdy_r, len_r;
  logic signed [TW-1:0] tx_r, ty_r;
  logic [KW-1:0] k_r;
  logic side_r, hit_r, stop_r;
  logic [33:0] mx_r, my_r;
  logic [5:0]  ph_r;
  grc_out_t    o_r;
  logic        ostb_r;

  // restoring divide of 2^NB by magnitude, one bit a cycle
  logic [NB+1:0] trial;
  logic [15:0]   dv;
  assign dv    = axis_r ? j_r.ay : j_r.ax;
  assign trial = {rem_r, (bit_r == 6'(NB))};

  // DDA step
  logic take_x;
  logic signed [TW-1:0] ntx, nty;
  logic out_map;
  logic [MAP_SIZE-1:0] rowsel;
  assign take_x = sdx_r < sdy_r;
  assign ntx = take_x ? (j_r.nx ? tx_r - 1'b1 : tx_r + 1'b1) : tx_r;
  assign nty = take_x ? ty_r : (j_r.ny ? ty_r - 1'b1 : ty_r + 1'b1);
  assign out_map = ntx < 0 || ntx >= TW'(MAP_SIZE) || nty < 0 || nty >= TW'(MAP_SIZE);
  assign rowsel = rows_r[nty[$clog2(MAP_SIZE)-1:0]];

  logic [FRAC_BITS-1:0] fx, fy;
  logic [FRAC_BITS:0] wx, wy;
  assign fx = j_r.sx[FRAC_BITS-1:0];
  assign fy = j_r.sy[FRAC_BITS-1:0];
  assign wx = j_r.nx ? {1'b0, fx} : ONE - {1'b0, fx};
  assign wy = j_r.ny ? {1'b0, fy} : ONE - {1'b0, fy};

  function automatic logic [16:0] endc(input logic [15:0] s, input logic n,
                                       input logic [33:0] m);
    logic [19:0] off;
    logic [20:0] r;
    begin
      off = 20'(m >> DIR_FRAC);
      if (n) r = (21'(off) >= 21'(s)) ? 21'd0 : 21'(s) - 21'(off);
      else   r = 21'(s) + 21'(off);
      endc = (r > 21'(TOP)) ? TOP : r[16:0];
    end
  endfunction

  assign q_pop      = st_r == S_IDLE && q_valid;
  assign out_strobe = ostb_r;
  assign out_data   = o_r;
  assign idle       = st_r == S_IDLE && !q_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAP_SIZE; i++) rows_r[i] <= '0;
    end else if (row_we) begin
      rows_r[row_idx[$clog2(MAP_SIZE)-1:0]] <= MAP_SIZE'(row_val);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; ostb_r <= 1'b0;
    end else begin
      ostb_r <= st_r == S_OUT;
      case (st_r)
        S_IDLE: if (q_valid) begin
          j_r <= q_job; axis_r <= 1'b0; bit_r <= 6'(NB);
          rem_r <= '0; quo_r <= '0;
          st_r <= S_DIV;
        end
        S_DIV: begin
          if (bit_r == 6'd0) begin
            bit_r <= 6'(NB); rem_r <= '0; quo_r <= '0;
            if (!axis_r) begin
              dx_r <= (dv == 16'd0) ? RSAT :
                ((trial >= (NB+2)'(dv)) ? (quo_r | DW'(1)) : quo_r);
              axis_r <= 1'b1;
            end else begin
              dy_r <= (dv == 16'd0) ? RSAT :
                ((trial >= (NB+2)'(dv)) ? (quo_r | DW'(1)) : quo_r);
              st_r <= S_INIT;
            end
          end else begin
            if (trial >= (NB+2)'(dv)) begin
              rem_r   <= (NB+1)'(trial - (NB+2)'(dv));
              quo_r[bit_r[$clog2(DW)-1:0]] <= 1'b1;
            end else rem_r <= trial[NB:0];
            bit_r <= bit_r - 6'd1;
          end
        end
        S_INIT: begin
          sdx_r <= SW'((64'(wx) * 64'(dx_r)) >> FRAC_BITS);
          sdy_r <= SW'((64'(wy) * 64'(dy_r)) >> FRAC_BITS);
          tx_r <= TW'(j_r.sx >> FRAC_BITS);
          ty_r <= TW'(j_r.sy >> FRAC_BITS);
          k_r <= '0; hit_r <= 1'b0; stop_r <= 1'b0;
          st_r <= j_r.oob ? S_OUT : S_WALK;
        end
        S_WALK: begin
          if (take_x) begin
            len_r <= sdx_r; sdx_r <= sdx_r + SW'(dx_r); side_r <= 1'b0;
          end else begin
            len_r <= sdy_r; sdy_r <= sdy_r + SW'(dy_r); side_r <= 1'b1;
          end
          tx_r <= ntx; ty_r <= nty; k_r <= k_r + 1'b1;
          if (out_map) st_r <= S_OUT;
          else if (rowsel[ntx[$clog2(MAP_SIZE)-1:0]]) begin
            hit_r <= 1'b1; st_r <= S_END; ph_r <= '0;
          end else if (32'(k_r) == 2 * MAP_SIZE - 1) st_r <= S_OUT;
        end
        S_END: begin
          if (len_r > LMAX) len_r <= LMAX;
          ph_r <= ph_r + 6'd1;
          if (ph_r == 6'd1) begin
            mx_r <= 34'(j_r.ax) * 34'(len_r[17:0]);
            my_r <= 34'(j_r.ay) * 34'(len_r[17:0]);
            st_r <= S_OUT; stop_r <= 1'b1;
          end
        end
        S_OUT: begin
          if (hit_r && stop_r) begin
            o_r.hit <= 1'b1; o_r.side <= side_r;
            o_r.tile_x <= 4'(tx_r); o_r.tile_y <= 4'(ty_r);
            o_r.ray_length <= len_r[17:0];
            o_r.end_x <= endc(j_r.sx, j_r.nx, mx_r);
            o_r.end_y <= endc(j_r.sy, j_r.ny, my_r);
          end else o_r <= '0;
          st_r <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire
